>>> rtl/ufm_pkg.sv
// ----------------------------------------------------------------------------
// ufm_pkg
// Shared constants and types for the UDP flood monitor flow table.
// ----------------------------------------------------------------------------
package ufm_pkg;
	localparam int FLOW_ENTRIES = 128;
	localparam int SLOT_W = $clog2(FLOW_ENTRIES);
	localparam logic [15:0] IPV4_KIND = 16'h0800;
	localparam logic [19:0] US_PER_SEC = 20'd1000000;
	localparam logic [1:0] REG_PROTO = 2'd0;
	localparam logic [1:0] REG_THRESH = 2'd1;
	localparam logic [1:0] REG_INTERVAL = 2'd2;
	localparam logic [1:0] REG_LEARN = 2'd3;

	typedef struct packed {
		logic        valid;
		logic        found;
		logic [SLOT_W-1:0] slot;
		logic [31:0] count;
	} match_t;

	typedef struct packed {
		logic        wr;
		logic        hit;
		logic [SLOT_W-1:0] slot;
		logic [31:0] addr;
		logic [15:0] port;
	} update_t;
endpackage

>>> rtl/udp_flood_monitor_flow_table.sv
// ----------------------------------------------------------------------------
// udp_flood_monitor_flow_table
// Packet-rate flood monitor with a destination flow table.
// ----------------------------------------------------------------------------
// A header is taken into the key registers, its flow key is then compared
// across the chain of table cells in S_MATCH, where the result is registered,
// and S_OUT raises out_valid. A packet that closes an interval runs the rate
// through a bit-serial divider (S_DIV0, S_DIV) before S_OUT. One packet is in
// flight at a time; the result register holds until taken, and the next
// packet is taken as the result leaves.
module udp_flood_monitor_flow_table (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic [15:0] ether_kind,
	input  logic [7:0] ip_proto,
	input  logic [31:0] dest_addr,
	input  logic [15:0] dest_port_num,
	input  logic [15:0] frame_length,
	input  logic [47:0] time_us,
	output logic out_valid,
	input  logic out_stall,
	output logic accepted,
	output logic flow_hit,
	output logic [6:0] flow_slot,
	output logic [31:0] flow_packets,
	output logic interval_done,
	output logic alarm,
	output logic [31:0] interval_packets_out,
	output logic [47:0] interval_bytes_out,
	output logic [31:0] rate_pps,
	output logic [31:0] threshold_now_out
);
	import ufm_pkg::*;

	typedef enum logic [2:0] {S_IDLE, S_MATCH, S_DIV0, S_DIV, S_OUT} state_t;
	state_t state_q;

	logic [7:0]  proto_q;
	logic [31:0] len_q;
	logic        learn_q;
	logic [31:0] wthr_q;
	logic [SLOT_W-1:0] ins_q;
	logic        seen_q;
	logic [47:0] start_q;
	logic [31:0] ipk_q;
	logic [47:0] ibytes_q;

	logic [31:0] k_addr_q;
	logic [15:0] k_port_q;
	logic [15:0] k_len_q;
	logic [47:0] k_time_q;
	logic        k_acc_q;
	logic [47:0] elapsed_q;
	logic [31:0] cls_pk_q;

	match_t chain [FLOW_ENTRIES+1];
	update_t upd;

	logic        div_start, div_busy, div_rnz;
	logic [51:0] div_q;
	logic        in_take;

	assign cfg_ready = 1'b1;
	assign in_stall = state_q != S_IDLE || (out_valid && out_stall);
	assign in_take = in_valid && !in_stall;

	assign chain[0] = '0;

	always_comb begin
		upd = '0;
		upd.wr = state_q == S_MATCH && k_acc_q;
		upd.hit = chain[FLOW_ENTRIES].found;
		upd.slot = chain[FLOW_ENTRIES].found ? chain[FLOW_ENTRIES].slot : ins_q;
		upd.addr = k_addr_q;
		upd.port = k_port_q;
	end

	for (genvar g = 0; g < FLOW_ENTRIES; g++) begin : g_cell
		ufm_cell u_cell (
			.clk(clk), .arst_n(arst_n), .my_slot(SLOT_W'(g)),
			.key_addr(k_addr_q), .key_port(k_port_q),
			.match_in(chain[g]), .match_out(chain[g+1]), .upd(upd)
		);
	end

	logic [31:0] pk_next;
	logic [48:0] by_sum;
	logic [47:0] st_eff, el;
	logic [31:0] lim;
	assign pk_next = (ipk_q != 32'hFFFF_FFFF) ? ipk_q + 32'd1 : ipk_q;
	assign by_sum = {1'b0, ibytes_q} + {33'd0, k_len_q};
	assign st_eff = seen_q ? start_q : k_time_q;
	assign el = (k_time_q >= st_eff) ? k_time_q - st_eff : 48'd0;
	assign lim = (len_q == 32'd0) ? 32'd1 : len_q;
	assign div_start = state_q == S_DIV0;

	ufm_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend({20'd0, cls_pk_q} * {32'd0, US_PER_SEC}),
		.divisor(elapsed_q), .busy(div_busy), .quot(div_q), .rem_nz(div_rnz)
	);

	logic above;
	assign above = div_q > {20'd0, wthr_q} || (div_q == {20'd0, wthr_q} && div_rnz);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			proto_q <= 8'd17;
			len_q <= 32'd30000000;
			learn_q <= 1'b0;
			wthr_q <= 32'd3000;
			ins_q <= '0;
			seen_q <= 1'b0;
			start_q <= '0;
			ipk_q <= '0;
			ibytes_q <= '0;
			out_valid <= 1'b0;
			accepted <= 1'b0;
			flow_hit <= 1'b0;
			flow_slot <= '0;
			flow_packets <= '0;
			interval_done <= 1'b0;
			alarm <= 1'b0;
			interval_packets_out <= '0;
			interval_bytes_out <= '0;
			rate_pps <= '0;
			threshold_now_out <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_PROTO: proto_q <= cfg_data[7:0];
					REG_THRESH: wthr_q <= cfg_data;
					REG_INTERVAL: len_q <= cfg_data;
					REG_LEARN: learn_q <= cfg_data[0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						state_q <= S_MATCH;
						out_valid <= 1'b0;
					end else if (!out_stall) begin
						out_valid <= 1'b0;
					end
				end
				S_MATCH: begin
					accepted <= k_acc_q;
					flow_hit <= 1'b0;
					flow_slot <= '0;
					flow_packets <= '0;
					interval_done <= 1'b0;
					alarm <= 1'b0;
					interval_packets_out <= '0;
					interval_bytes_out <= '0;
					rate_pps <= '0;
					threshold_now_out <= wthr_q;
					state_q <= S_OUT;
					if (k_acc_q) begin
						flow_hit <= upd.hit;
						flow_slot <= 7'(upd.slot);
						flow_packets <= upd.hit ? ((chain[FLOW_ENTRIES].count ==
							32'hFFFF_FFFF) ? 32'hFFFF_FFFF :
							chain[FLOW_ENTRIES].count + 32'd1) : 32'd1;
						if (!upd.hit) ins_q <= ins_q + 1'b1;
						seen_q <= 1'b1;
						if (el >= {16'd0, lim}) begin
							interval_done <= 1'b1;
							interval_packets_out <= pk_next;
							interval_bytes_out <= by_sum[48] ? 48'hFFFF_FFFF_FFFF :
								by_sum[47:0];
							ipk_q <= '0;
							ibytes_q <= '0;
							start_q <= k_time_q;
							state_q <= S_DIV0;
						end else begin
							ipk_q <= pk_next;
							ibytes_q <= by_sum[48] ? 48'hFFFF_FFFF_FFFF : by_sum[47:0];
							start_q <= st_eff;
						end
					end
				end
				S_DIV0: state_q <= S_DIV;
				S_DIV: begin
					if (!div_busy) begin
						rate_pps <= (div_q[51:32] != 20'd0) ? 32'hFFFF_FFFF : div_q[31:0];
						if (above && learn_q) begin
							wthr_q <= (div_q[51:32] != 20'd0) ? 32'hFFFF_FFFF : div_q[31:0];
							threshold_now_out <= (div_q[51:32] != 20'd0) ? 32'hFFFF_FFFF :
								div_q[31:0];
						end
						alarm <= above && !learn_q;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					out_valid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			k_addr_q <= dest_addr;
			k_port_q <= dest_port_num;
			k_len_q <= frame_length;
			k_time_q <= time_us;
			k_acc_q <= ether_kind == IPV4_KIND && ip_proto == proto_q;
		end
		if (state_q == S_MATCH) begin
			elapsed_q <= el;
			cls_pk_q <= pk_next;
		end
	end

	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> in_stall) else $error("accepted during division");
	a_done_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && interval_done) |-> accepted) else $error("close without accept");
	a_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && alarm) |-> interval_done) else $error("alarm outside close");
endmodule

>>> rtl/ufm_cell.sv
// ----------------------------------------------------------------------------
// ufm_cell
// One flow table entry; merges its compare result into the match chain.
// ----------------------------------------------------------------------------
module ufm_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic [ufm_pkg::SLOT_W-1:0] my_slot,
	input  logic [31:0] key_addr,
	input  logic [15:0] key_port,
	input  ufm_pkg::match_t match_in,
	output ufm_pkg::match_t match_out,
	input  ufm_pkg::update_t upd
);
	import ufm_pkg::*;
	logic        valid_q;
	logic [31:0] addr_q;
	logic [15:0] port_q;
	logic [31:0] count_q;
	logic        mine;

	assign mine = valid_q && addr_q == key_addr && port_q == key_port;

	always_comb begin
		match_out = match_in;
		if (!match_in.found && mine) begin
			match_out.found = 1'b1;
			match_out.slot = my_slot;
			match_out.count = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (upd.wr && upd.slot == my_slot) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (upd.wr && upd.slot == my_slot) begin
			if (upd.hit) begin
				if (count_q != 32'hFFFF_FFFF) count_q <= count_q + 32'd1;
			end else begin
				addr_q <= upd.addr;
				port_q <= upd.port;
				count_q <= 32'd1;
			end
		end
	end
endmodule

>>> rtl/ufm_divider.sv
// ----------------------------------------------------------------------------
// ufm_divider
// Radix-2 restoring divider, 52-bit dividend by 48-bit divisor.
// ----------------------------------------------------------------------------
module ufm_divider (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [51:0] dividend,
	input  logic [47:0] divisor,
	output logic busy,
	output logic [51:0] quot,
	output logic rem_nz
);
	logic [5:0]  cnt_q;
	logic [51:0] q_q;
	logic [48:0] r_q;
	logic [47:0] d_q;
	logic [48:0] trial;

	assign trial = {r_q[47:0], q_q[51]};
	assign busy = cnt_q != 6'd0;
	assign quot = q_q;
	assign rem_nz = r_q != 49'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 6'd0;
		end else if (start) begin
			cnt_q <= 6'd52;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= 49'd0;
			d_q <= divisor;
		end else if (busy) begin
			if (trial >= {1'b0, d_q}) begin
				r_q <= trial - {1'b0, d_q};
				q_q <= {q_q[50:0], 1'b1};
			end else begin
				r_q <= trial;
				q_q <= {q_q[50:0], 1'b0};
			end
		end
	end
endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flood monitor flow table testbench
// Drives parsed packet headers and register writes into the monitor, keeps a
// behavioural copy of the flow table and interval counters, and checks every
// result transaction field by field against it, under random idling on both
// sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
	import ufm_pkg::*;

	typedef struct {
		logic [15:0] kind;
		logic [7:0]  proto;
		logic [31:0] addr;
		logic [15:0] port;
		logic [15:0] len;
		logic [47:0] t;
	} pkt_t;

	typedef struct packed {
		logic        acc;
		logic        hit;
		logic [6:0]  slot;
		logic [31:0] fpkts;
		logic        done;
		logic        alarm;
		logic [31:0] ipkts;
		logic [47:0] ibytes;
		logic [31:0] rate;
		logic [31:0] thr;
	} verdict_t;

	class flood_scoreboard;
		logic [7:0]  proto_sel;
		logic [31:0] thr_init;
		logic [31:0] ilen;
		logic        learn;
		logic [31:0] f_addr [FLOW_ENTRIES];
		logic [15:0] f_port [FLOW_ENTRIES];
		logic [31:0] f_cnt [FLOW_ENTRIES];
		logic        f_val [FLOW_ENTRIES];
		int          ins_ptr;
		bit          started;
		logic [47:0] t_start;
		logic [31:0] pkts;
		logic [47:0] bytes;
		logic [31:0] thr;
		verdict_t    pending[$];
		int          errors;

		function void clear();
			proto_sel = 17; thr_init = 3000; ilen = 30000000; learn = 0;
			for (int i = 0; i < FLOW_ENTRIES; i++) begin
				f_addr[i] = 0; f_port[i] = 0; f_cnt[i] = 0; f_val[i] = 0;
			end
			ins_ptr = 0; started = 0; t_start = 0; pkts = 0; bytes = 0;
			thr = 3000; errors = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [31:0] d);
			case (idx)
				REG_PROTO: proto_sel = d[7:0];
				REG_THRESH: begin
					thr_init = d;
					thr = d;
				end
				REG_INTERVAL: ilen = d;
				REG_LEARN: learn = d[0];
				default: ;
			endcase
		endfunction

		function void note_packet(pkt_t p);
			verdict_t v;
			int s;
			bit hit;
			logic [63:0] el, lim, sc, q, r, sum;
			v = '{default: 0};
			if (p.kind == IPV4_KIND && p.proto == proto_sel) begin
				if (pkts != 32'hFFFF_FFFF) pkts++;
				sum = {16'd0, bytes} + p.len;
				bytes = (sum > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : sum[47:0];
				hit = 0; s = 0;
				for (int i = 0; i < FLOW_ENTRIES; i++)
					if (!hit && f_val[i] && f_addr[i] == p.addr && f_port[i] == p.port) begin
						hit = 1;
						s = i;
					end
				if (hit) begin
					if (f_cnt[s] != 32'hFFFF_FFFF) f_cnt[s]++;
				end else begin
					s = ins_ptr;
					f_addr[s] = p.addr; f_port[s] = p.port; f_cnt[s] = 1; f_val[s] = 1;
					ins_ptr = (s + 1) % FLOW_ENTRIES;
				end
				v.acc = 1; v.hit = hit; v.slot = s[6:0]; v.fpkts = f_cnt[s];
				if (!started) begin
					started = 1;
					t_start = p.t;
				end
				el = (p.t >= t_start) ? p.t - t_start : 0;
				lim = (ilen == 0) ? 1 : ilen;
				if (el >= lim) begin
					sc = pkts * 64'd1000000;
					q = sc / el;
					r = sc % el;
					v.done = 1;
					v.rate = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
					if (q > thr || (q == thr && r != 0)) begin
						if (learn) thr = v.rate;
						else v.alarm = 1;
					end
					v.ipkts = pkts; v.ibytes = bytes;
					pkts = 0; bytes = 0; t_start = p.t;
				end
			end
			v.thr = thr;
			pending.push_back(v);
		endfunction

		function void check_result(verdict_t a);
			verdict_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result transaction at %0t", $realtime);
				return;
			end
			e = pending.pop_front();
			if (a !== e) begin
				errors++;
				if (errors <= 10)
					$display("mismatch at %0t: exp %p act %p", $realtime, e, a);
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic cfg_valid, cfg_ready;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;
	logic in_valid, in_stall, out_valid, out_stall;
	logic [15:0] ether_kind, dest_port_num, frame_length;
	logic [7:0] ip_proto;
	logic [31:0] dest_addr;
	logic [47:0] time_us;
	logic accepted, flow_hit, interval_done, alarm;
	logic [6:0] flow_slot;
	logic [31:0] flow_packets, interval_packets_out, rate_pps, threshold_now_out;
	logic [47:0] interval_bytes_out;

	flood_scoreboard sb;
	bit calm;
	bit hold_req;
	logic [47:0] clock_us;
	logic [31:0] addr_pool [8];
	logic [15:0] port_pool [8];

	udp_flood_monitor_flow_table dut (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("TEST FAILED");
		$finish;
	end

	// output side: random stall bursts plus one long hold-off on request
	initial begin
		int n;
		out_stall = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1;
				repeat (300) @(posedge clk);
				out_stall <= 0;
				hold_req = 0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 3);
				out_stall <= 1;
				repeat (n) @(posedge clk);
				out_stall <= 0;
			end
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sb.check_result('{accepted, flow_hit, flow_slot, flow_packets, interval_done,
				alarm, interval_packets_out, interval_bytes_out, rate_pps,
				threshold_now_out});

	task automatic send_packet(pkt_t p);
		cfg_valid <= 0;
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1;
		ether_kind <= p.kind; ip_proto <= p.proto; dest_addr <= p.addr;
		dest_port_num <= p.port; frame_length <= p.len; time_us <= p.t;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_packet(p);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] d);
		cfg_valid <= 1; cfg_index <= idx; cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.write_reg(idx, d);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		in_valid <= 0;
		while (sb.pending.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (80) @(posedge clk);
	endtask

	function automatic pkt_t rand_packet();
		pkt_t p;
		int k;
		k = $urandom_range(0, 9);
		p.kind = (k == 0) ? 16'($urandom) : IPV4_KIND;
		p.proto = (k == 1) ? 8'($urandom) : sb.proto_sel;
		if ($urandom_range(0, 3) == 0) begin
			p.addr = $urandom;
			p.port = 16'($urandom);
		end else begin
			p.addr = addr_pool[$urandom_range(0, 7)];
			p.port = port_pool[$urandom_range(0, 7)];
		end
		p.len = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom);
		clock_us += $urandom_range(0, 3) == 0 ? $urandom_range(0, 3000) : $urandom_range(0, 40);
		p.t = clock_us;
		return p;
	endfunction

	task automatic run_phase(int n);
		for (int i = 0; i < n; i++) send_packet(rand_packet());
	endtask

	initial begin
		pkt_t p;
		sb = new();
		sb.clear();
		calm = 0; hold_req = 0; clock_us = 0;
		for (int i = 0; i < 8; i++) begin
			addr_pool[i] = $urandom;
			port_pool[i] = 16'($urandom);
		end
		arst_n = 0;
		cfg_valid = 0; cfg_index = 0; cfg_data = 0; in_valid = 0;
		ether_kind = 0; ip_proto = 0; dest_addr = 0; dest_port_num = 0;
		frame_length = 0; time_us = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: defaults, rejects, extremes
		send_packet('{IPV4_KIND, 8'd17, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 48'd0});
		send_packet('{16'h86DD, 8'd17, 32'h0, 16'h0, 16'h0, 48'd5});
		send_packet('{IPV4_KIND, 8'd6, 32'h0, 16'h0, 16'h0, 48'd5});
		send_packet('{IPV4_KIND, 8'd17, 32'hFFFF_FFFF, 16'hFFFF, 16'h0, 48'd10});
		send_packet('{IPV4_KIND, 8'd17, 32'h0, 16'h0, 16'h1, 48'd30000010});
		drain();
		write_reg(REG_INTERVAL, 32'd0);
		write_reg(REG_THRESH, 32'd0);
		send_packet('{IPV4_KIND, 8'd17, 32'h1, 16'h1, 16'hFFFF, 48'd30000010});
		send_packet('{IPV4_KIND, 8'd17, 32'h1, 16'h1, 16'hFFFF, 48'd30000011});
		send_packet('{IPV4_KIND, 8'd17, 32'h1, 16'h1, 16'hFFFF, 48'hFFFF_FFFF_FFFF});
		send_packet('{IPV4_KIND, 8'd17, 32'h2, 16'h1, 16'h5, 48'hFFFF_FFFF_FFFF});
		drain();
		write_reg(REG_LEARN, 32'd1);
		write_reg(REG_PROTO, 32'd255);
		write_reg(REG_INTERVAL, 32'hFFFF_FFFF);
		send_packet('{16'hFFFF, 8'd255, 32'h3, 16'h3, 16'h3, 48'hFFFF_FFFF_FFFF});
		send_packet('{IPV4_KIND, 8'd255, 32'h3, 16'h3, 16'h3, 48'hFFFF_FFFF_FFFF});
		drain();

		// fill the table past wrap-around, with a long output hold-off
		write_reg(REG_PROTO, 32'd17);
		write_reg(REG_LEARN, 32'd0);
		write_reg(REG_THRESH, 32'hFFFF_FFFF);
		write_reg(REG_INTERVAL, 32'd500);
		hold_req = 1;
		for (int i = 0; i < 140; i++) begin
			p = rand_packet();
			p.kind = IPV4_KIND; p.proto = 8'd17; p.addr = $urandom;
			send_packet(p);
		end
		drain();

		write_reg(REG_THRESH, 32'd2000);
		write_reg(REG_INTERVAL, 32'd1);
		run_phase(120);
		drain();
		write_reg(REG_LEARN, 32'd1);
		write_reg(REG_THRESH, 32'd100);
		write_reg(REG_INTERVAL, 32'd300);
		run_phase(120);
		drain();
		write_reg(REG_LEARN, 32'd0);
		write_reg(REG_PROTO, 32'd6);
		write_reg(REG_INTERVAL, 32'd2000);
		run_phase(60);
		calm = 1;
		run_phase(60);
		drain();

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule

>>> udp_flood_monitor_flow_table.f
rtl/ufm_pkg.sv
rtl/ufm_cell.sv
rtl/ufm_divider.sv
rtl/udp_flood_monitor_flow_table.sv
dv/tb_top.sv
